// ===== hw/rtl/rdct_pkg.sv =====
// Shared types and codes for the reload down counter timer.
`timescale 1ns / 1ps
`default_nettype none
package rdct_pkg;

    localparam int unsigned DATA_W = 32;

    // Request types
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;
    localparam logic [1:0] REQ_NONE  = 2'd3;

    // Register selects
    localparam logic [1:0] REG_CTRL    = 2'd0;
    localparam logic [1:0] REG_RELOAD  = 2'd1;
    localparam logic [1:0] REG_VALUE   = 2'd2;
    localparam logic [1:0] REG_ELAPSED = 2'd3;

    // Control register bit positions
    localparam int unsigned CTRL_EN_BIT   = 0;
    localparam int unsigned CTRL_IRQ_BIT  = 1;
    localparam int unsigned CTRL_SRC_BIT  = 2;
    localparam int unsigned CTRL_FLAG_BIT = 16;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [1:0]        reg_sel;
        logic [DATA_W-1:0] write_data;
    } t_req;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              tick_irq;
        logic              running;
    } t_rsp;

endpackage
`default_nettype wire

// ===== hw/rtl/rdct_core.sv =====
// Timer state and the per-beat register and counter logic.
`timescale 1ns / 1ps
`default_nettype none
module rdct_core import rdct_pkg::*; #(
    parameter int unsigned COUNT_WIDTH  = 24,
    parameter int unsigned PRESCALE_DIV = 8
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cfg_we,
    input  wire logic i_cfg_wdata,
    input  wire logic i_take,
    input  wire t_req i_req,
    output t_rsp      o_rsp
);

    localparam int unsigned PS_W = $clog2(PRESCALE_DIV);
    localparam logic [PS_W-1:0] PS_LAST = PS_W'(PRESCALE_DIV - 1);
    localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

    logic                   r_one_shot;
    logic [COUNT_WIDTH-1:0] r_count,  n_count;
    logic [COUNT_WIDTH-1:0] r_reload, n_reload;
    logic                   r_en,     n_en;
    logic                   r_irq_en, n_irq_en;
    logic                   r_src,    n_src;
    logic                   r_flag,   n_flag;
    logic [PS_W-1:0]        r_ps,     n_ps;

    logic                   step;
    logic                   pulse;
    logic [DATA_W-1:0]      rd;
    logic [COUNT_WIDTH-1:0] elapsed;

    // The difference wraps at the counter width before it is widened.
    assign elapsed = r_reload - r_count;

    always_comb begin
        n_count  = r_count;
        n_reload = r_reload;
        n_en     = r_en;
        n_irq_en = r_irq_en;
        n_src    = r_src;
        n_flag   = r_flag;
        n_ps     = r_ps;
        step     = 1'b0;
        pulse    = 1'b0;
        rd       = '0;

        unique case (i_req.req_type)
            REQ_TICK: begin
                if (r_en) begin
                    if (r_src) begin
                        step = 1'b1;
                    end else if (r_ps >= PS_LAST) begin
                        n_ps = '0;
                        step = 1'b1;
                    end else begin
                        n_ps = r_ps + PS_W'(1);
                    end
                end
            end
            REQ_READ: begin
                unique case (i_req.reg_sel)
                    REG_CTRL: begin
                        rd[CTRL_EN_BIT]   = r_en;
                        rd[CTRL_IRQ_BIT]  = r_irq_en;
                        rd[CTRL_SRC_BIT]  = r_src;
                        rd[CTRL_FLAG_BIT] = r_flag;
                        n_flag            = 1'b0;
                    end
                    REG_RELOAD:  rd = DATA_W'(r_reload);
                    REG_VALUE:   rd = DATA_W'(r_count);
                    REG_ELAPSED: rd = DATA_W'(elapsed);
                    default:     rd = '0;
                endcase
            end
            REQ_WRITE: begin
                unique case (i_req.reg_sel)
                    REG_CTRL: begin
                        n_en     = i_req.write_data[CTRL_EN_BIT];
                        n_irq_en = i_req.write_data[CTRL_IRQ_BIT];
                        n_src    = i_req.write_data[CTRL_SRC_BIT];
                    end
                    REG_RELOAD: n_reload = i_req.write_data[COUNT_WIDTH-1:0];
                    REG_VALUE: begin
                        n_count = '0;
                        n_flag  = 1'b0;
                        n_ps    = '0;
                    end
                    default: begin
                        // The elapsed register is read only.
                    end
                endcase
            end
            default: begin
            end
        endcase

        if (step) begin
            if (r_count == '0) begin
                n_count = r_reload;
            end else if (r_count == CNT_ONE) begin
                n_count = '0;
                n_flag  = 1'b1;
                pulse   = r_irq_en;
                if (r_one_shot) begin
                    n_en     = 1'b0;
                    n_irq_en = 1'b0;
                end
            end else begin
                n_count = r_count - CNT_ONE;
            end
        end
    end

    always_comb begin
        o_rsp.read_data = rd;
        o_rsp.tick_irq  = pulse;
        o_rsp.running   = n_en;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_one_shot <= 1'b0;
            r_count    <= '0;
            r_reload   <= '0;
            r_en       <= 1'b0;
            r_irq_en   <= 1'b0;
            r_src      <= 1'b0;
            r_flag     <= 1'b0;
            r_ps       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_one_shot <= i_cfg_wdata;
            end
            if (i_take) begin
                r_count  <= n_count;
                r_reload <= n_reload;
                r_en     <= n_en;
                r_irq_en <= n_irq_en;
                r_src    <= n_src;
                r_flag   <= n_flag;
                r_ps     <= n_ps;
            end
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/reload_down_counter_timer.sv =====
// Top level of the reload down counter timer with its output skid stage.
// A result is registered in the output or skid register when its request beat is accepted.
// Throughput: one beat per cycle while the input is not stalled; the timer state updates in the accept cycle.
// A stalled output parks one further result in a skid register, after which
// the input stalls until the output drains.
// Reset is synchronous and active low; all timer state and valids clear to zero.
`timescale 1ns / 1ps
`default_nettype none
module reload_down_counter_timer import rdct_pkg::*; #(
    parameter int unsigned COUNT_WIDTH  = 24,
    parameter int unsigned PRESCALE_DIV = 8
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cfg_we,
    input  wire logic i_cfg_wdata,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    input  wire t_req i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output t_rsp      o_out_data
);

    logic take;
    logic out_free;
    t_rsp rsp;

    logic r_out_valid;
    logic r_skid_valid;
    t_rsp r_out;
    t_rsp r_skid;

    assign take     = i_in_valid && !r_skid_valid;
    assign out_free = !r_out_valid || !i_out_stall;

    rdct_core #(
        .COUNT_WIDTH  (COUNT_WIDTH),
        .PRESCALE_DIV (PRESCALE_DIV)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_take      (take),
        .i_req       (i_in_data),
        .o_rsp       (rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (out_free) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= take;
                end
            end else if (take) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    // Payload side: the skid holds the beat that arrived while the output was stalled.
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (take) begin
                r_out <= rsp;
            end
        end else if (take) begin
            r_skid <= rsp;
        end
    end

    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds a beat while the output is empty");

    a_skid_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(i_out_stall))
        else $error("skid register filled without an output stall");

    a_irq_not_on_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && rsp.tick_irq) |-> (rsp.read_data == '0))
        else $error("interrupt pulse raised on a beat with read data");

endmodule
`default_nettype wire

// ===== verif/reload_down_counter_timer_test.sv =====
// Self-checking testbench for the reload down counter timer, with its own timer model.
`timescale 1ns / 1ps
module reload_down_counter_timer_test import rdct_pkg::*;;

    localparam int unsigned COUNT_WIDTH  = 24;
    localparam int unsigned PRESCALE_DIV = 8;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned PHASE_ITEMS  = 325;

    typedef struct {
        t_req req;
        bit   typed;
        t_rsp rsp;
    } t_stim_row;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic cfg_we    = 1'b0;
    logic cfg_wdata = 1'b0;
    logic in_valid  = 1'b0;
    t_req in_data   = '0;
    logic out_stall = 1'b0;
    logic in_stall;
    logic out_valid;
    t_rsp out_data;

    // Timer model state.
    logic [COUNT_WIDTH-1:0] tm_count    = '0;
    logic [COUNT_WIDTH-1:0] tm_reload   = '0;
    logic                   tm_enable   = 1'b0;
    logic                   tm_irq_en   = 1'b0;
    logic                   tm_source   = 1'b0;
    logic                   tm_flag     = 1'b0;
    logic [2:0]             tm_prescale = '0;
    logic                   tm_one_shot = 1'b0;

    t_rsp        pending_results[$];
    t_stim_row   directed_rows[$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int unsigned send_idle_pct  = 38;
    int unsigned recv_idle_pct  = 49;
    t_rsp        want_rsp;

    reload_down_counter_timer #(
        .COUNT_WIDTH  (COUNT_WIDTH),
        .PRESCALE_DIV (PRESCALE_DIV)
    ) u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // One step of the counter itself; returns the interrupt pulse.
    function automatic logic count_down_step();
        logic pulse;
        pulse = 1'b0;
        if (tm_count == '0) begin
            tm_count = tm_reload;
        end else if (tm_count == COUNT_WIDTH'(1)) begin
            tm_count = '0;
            tm_flag  = 1'b1;
            pulse    = tm_irq_en;
            if (tm_one_shot) begin
                tm_enable = 1'b0;
                tm_irq_en = 1'b0;
            end
        end else begin
            tm_count = tm_count - COUNT_WIDTH'(1);
        end
        return pulse;
    endfunction

    function automatic t_rsp compute_timer_result(input t_req req);
        t_rsp                   rsp;
        logic [COUNT_WIDTH-1:0] elapsed;
        rsp = '0;
        case (req.req_type)
            REQ_TICK: begin
                if (tm_enable) begin
                    if (tm_source) begin
                        rsp.tick_irq = count_down_step();
                    end else if (tm_prescale == 3'(PRESCALE_DIV - 1)) begin
                        tm_prescale  = '0;
                        rsp.tick_irq = count_down_step();
                    end else begin
                        tm_prescale = tm_prescale + 3'd1;
                    end
                end
            end
            REQ_READ: begin
                case (req.reg_sel)
                    REG_CTRL: begin
                        rsp.read_data[CTRL_EN_BIT]   = tm_enable;
                        rsp.read_data[CTRL_IRQ_BIT]  = tm_irq_en;
                        rsp.read_data[CTRL_SRC_BIT]  = tm_source;
                        rsp.read_data[CTRL_FLAG_BIT] = tm_flag;
                        tm_flag = 1'b0;
                    end
                    REG_RELOAD:  rsp.read_data = DATA_W'(tm_reload);
                    REG_VALUE:   rsp.read_data = DATA_W'(tm_count);
                    default: begin
                        elapsed       = tm_reload - tm_count;
                        rsp.read_data = DATA_W'(elapsed);
                    end
                endcase
            end
            REQ_WRITE: begin
                case (req.reg_sel)
                    REG_CTRL: begin
                        tm_enable = req.write_data[CTRL_EN_BIT];
                        tm_irq_en = req.write_data[CTRL_IRQ_BIT];
                        tm_source = req.write_data[CTRL_SRC_BIT];
                    end
                    REG_RELOAD: tm_reload = req.write_data[COUNT_WIDTH-1:0];
                    REG_VALUE: begin
                        tm_count    = '0;
                        tm_flag     = 1'b0;
                        tm_prescale = '0;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        rsp.running = tm_enable;
        return rsp;
    endfunction

    // Mostly ticks, with enough reload and control writes to keep the counter
    // wrapping through zero and being re-armed after one-shot stops.
    function automatic t_req random_request();
        t_req        req;
        int unsigned roll;
        roll           = $urandom_range(0, 99);
        req.write_data = $urandom();
        req.reg_sel    = 2'($urandom_range(0, 3));
        req.req_type   = REQ_WRITE;
        if (roll < 58) begin
            req.req_type = REQ_TICK;
        end else if (roll < 76) begin
            req.req_type = REQ_READ;
        end else if (roll < 84) begin
            req.reg_sel = REG_RELOAD;
            if ($urandom_range(0, 9) < 8)
                req.write_data[COUNT_WIDTH-1:0] = COUNT_WIDTH'($urandom_range(0, 12));
        end else if (roll < 92) begin
            req.reg_sel = REG_CTRL;
            req.write_data[CTRL_EN_BIT] = ($urandom_range(0, 9) < 8);
        end else if (roll < 95) begin
            req.reg_sel = REG_VALUE;
        end else if (roll < 97) begin
            req.reg_sel = REG_ELAPSED;
        end else begin
            req.req_type = REQ_NONE;
        end
        return req;
    endfunction

    function automatic void add_row(input logic [1:0] req_type, input logic [1:0] reg_sel,
                                    input logic [DATA_W-1:0] data, input bit typed,
                                    input logic [DATA_W-1:0] rd, input logic irq,
                                    input logic run);
        t_stim_row row;
        row.req.req_type   = req_type;
        row.req.reg_sel    = reg_sel;
        row.req.write_data = data;
        row.typed          = typed;
        row.rsp.read_data  = rd;
        row.rsp.tick_irq   = irq;
        row.rsp.running    = run;
        directed_rows.push_back(row);
    endfunction

    // Presents one beat, waits for it to be taken, and records what should come back.
    task automatic send_beat(input t_req req, input bit typed, input t_rsp typed_rsp);
        t_rsp predicted;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge clk); while (in_stall !== 1'b0);
        predicted = compute_timer_result(req);
        pending_results.push_back(typed ? typed_rsp : predicted);
    endtask

    task automatic wait_for_drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic set_one_shot(input logic value);
        wait_for_drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we      <= 1'b0;
        tm_one_shot = value;
    endtask

    always @(posedge clk) begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result beat with nothing pending");
            end else begin
                want_rsp = pending_results.pop_front();
                if (out_data.read_data !== want_rsp.read_data)
                    report_mismatch($sformatf("read_data %h, expected %h",
                                              out_data.read_data, want_rsp.read_data));
                if (out_data.tick_irq !== want_rsp.tick_irq)
                    report_mismatch($sformatf("tick_irq %b, expected %b",
                                              out_data.tick_irq, want_rsp.tick_irq));
                if (out_data.running !== want_rsp.running)
                    report_mismatch($sformatf("running %b, expected %b",
                                              out_data.running, want_rsp.running));
            end
        end
    end

    initial begin
        // Everything reads zero straight after reset, and disabled ticks do nothing.
        add_row(REQ_READ,  REG_CTRL,    32'h0000_0000, 1, 32'h0000_0000, 0, 0);
        add_row(REQ_READ,  REG_RELOAD,  32'h0000_0000, 1, 32'h0000_0000, 0, 0);
        add_row(REQ_READ,  REG_VALUE,   32'h0000_0000, 1, 32'h0000_0000, 0, 0);
        add_row(REQ_READ,  REG_ELAPSED, 32'h0000_0000, 1, 32'h0000_0000, 0, 0);
        add_row(REQ_TICK,  REG_CTRL,    32'hFFFF_FFFF, 1, 32'h0000_0000, 0, 0);
        // Full-width reload keeps only the counter bits.
        add_row(REQ_WRITE, REG_RELOAD,  32'hFFFF_FFFF, 1, 32'h0000_0000, 0, 0);
        add_row(REQ_READ,  REG_RELOAD,  32'h0000_0000, 1, 32'h00FF_FFFF, 0, 0);
        add_row(REQ_READ,  REG_ELAPSED, 32'h0000_0000, 1, 32'h00FF_FFFF, 0, 0);
        add_row(REQ_WRITE, REG_CTRL,    32'hFFFF_FFFF, 1, 32'h0000_0000, 0, 1);
        add_row(REQ_READ,  REG_CTRL,    32'h0000_0000, 1, 32'h0000_0007, 0, 1);
        add_row(REQ_TICK,  REG_RELOAD,  32'h0000_0000, 0, '0, 0, 0);
        add_row(REQ_TICK,  REG_VALUE,   32'h0000_0000, 0, '0, 0, 0);
        add_row(REQ_READ,  REG_ELAPSED, 32'h0000_0000, 0, '0, 0, 0);
        add_row(REQ_WRITE, REG_VALUE,   32'h0000_0000, 0, '0, 0, 0);
        add_row(REQ_READ,  REG_VALUE,   32'h0000_0000, 0, '0, 0, 0);
        // Reload of one: load, then reach zero with the interrupt enabled.
        add_row(REQ_WRITE, REG_RELOAD,  32'h0000_0001, 0, '0, 0, 0);
        add_row(REQ_TICK,  REG_CTRL,    32'h0000_0000, 0, '0, 0, 0);
        add_row(REQ_TICK,  REG_CTRL,    32'h0000_0000, 0, '0, 0, 0);
        add_row(REQ_READ,  REG_CTRL,    32'h0000_0000, 0, '0, 0, 0);
        add_row(REQ_READ,  REG_CTRL,    32'h0000_0000, 0, '0, 0, 0);
        add_row(REQ_WRITE, REG_RELOAD,  32'h0000_0000, 0, '0, 0, 0);
        add_row(REQ_TICK,  REG_ELAPSED, 32'h0000_0000, 0, '0, 0, 0);
        add_row(REQ_WRITE, REG_ELAPSED, 32'hFFFF_FFFF, 0, '0, 0, 0);
        add_row(REQ_NONE,  REG_ELAPSED, 32'hFFFF_FFFF, 0, '0, 0, 0);
        add_row(REQ_WRITE, REG_CTRL,    32'h0000_0003, 0, '0, 0, 0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_beat(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);

        for (int ph = 0; ph < 6; ph++) begin
            send_idle_pct = (ph < 2) ? 38 : (ph < 4) ? 49 : 0;
            recv_idle_pct = (ph < 2) ? 49 : (ph < 4) ? 38 : 0;
            set_one_shot(ph % 2 == 0);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 1 && n == PHASE_ITEMS / 2)
                    wait_for_drain();
                send_beat(random_request(), 1'b0, '0);
            end
        end

        wait_for_drain();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
